// ===== src/accel_tilt_angles_macros.svh =====
// Assertion macros shared by the tilt-angle checker.
// No dependencies; include by bare file name.
`ifndef ACCEL_TILT_ANGLES_MACROS_SVH
`define ACCEL_TILT_ANGLES_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ATL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ATL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/atl_pkg.sv =====
// Shared constants, types and the arctangent table for the tilt-angle block.
// No dependencies.
package atl_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int ANGLE_W          = 15;
    localparam int ANGLE_LIMIT      = 9000;
    // Radicand is always 62 bits: the sum of squares is pre-shifted by 2*(31 - width).
    localparam int RAD_W            = 62;
    localparam int ROOT_W           = RAD_W / 2;
    localparam int CORDIC_W         = 35;
    localparam int ACC_W            = 32;

    // atan(2^-i) in 0.01 degree with 16 fraction bits
    function automatic logic [ACC_W-1:0] atan_entry(input int idx);
        logic [ACC_W-1:0] v;
        case (idx)
            0:  v = 32'd294912000;
            1:  v = 32'd174096719;
            2:  v = 32'd91987925;
            3:  v = 32'd46694507;
            4:  v = 32'd23437865;
            5:  v = 32'd11730358;
            6:  v = 32'd5866610;
            7:  v = 32'd2933484;
            8:  v = 32'd1466765;
            9:  v = 32'd733385;
            10: v = 32'd366693;
            11: v = 32'd183346;
            12: v = 32'd91673;
            13: v = 32'd45837;
            14: v = 32'd22918;
            15: v = 32'd11459;
            16: v = 32'd5730;
            17: v = 32'd2865;
            18: v = 32'd1432;
            19: v = 32'd716;
            20: v = 32'd358;
            21: v = 32'd179;
            22: v = 32'd90;
            23: v = 32'd45;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/atl_isqrt.sv =====
// Pipelined digit-by-digit floor square root, one root bit per stage.
// Depends on atl_pkg.
module atl_isqrt import atl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [RAD_W-1:0]  i_rad,
    output logic [ROOT_W-1:0] o_root
);

    localparam int REM_W = ROOT_W + 2;
    localparam int CUR_W = ROOT_W + 4;

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RAD_W-1:0]  r_rest [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  w_rem_p;
        logic [ROOT_W-1:0] w_root_p;
        logic [RAD_W-1:0]  w_rest_p;
        logic [CUR_W-1:0]  w_cur;
        logic [CUR_W-1:0]  w_trial;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_rem_p  = '0;
            assign w_root_p = '0;
            assign w_rest_p = i_rad;
        end else begin : g_next
            assign w_rem_p  = r_rem[k-1];
            assign w_root_p = r_root[k-1];
            assign w_rest_p = r_rest[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign w_cur   = {w_rem_p, w_rest_p[RAD_W-1 -: 2]};
        assign w_trial = {2'b00, w_root_p, 2'b01};
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? REM_W'(w_cur - w_trial) : REM_W'(w_cur);
                r_root[k] <= {w_root_p[ROOT_W-2:0], w_ge};
                r_rest[k] <= {w_rest_p[RAD_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

// ===== src/atl_cordic.sv =====
// Pipelined CORDIC vectoring unit: angle of (magnitude, opposite side) in 0.01 degree,
// rounded and clamped. Depends on atl_pkg.
module atl_cordic import atl_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int STEPS        = CORDIC_STEPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [ROOT_W-1:0]         i_mag,
    input  logic signed [SAMPLE_WIDTH:0] i_opp,
    output logic signed [ANGLE_W-1:0] o_angle
);

    localparam int FRAC_H = 31 - SAMPLE_WIDTH;
    localparam int YS_PAD = CORDIC_W - (SAMPLE_WIDTH + 1) - FRAC_H;

    typedef struct packed {
        logic zero_mag;
        logic zero_opp;
        logic neg;
    } t_flags;

    logic signed [CORDIC_W-1:0] r_xs  [STEPS+1];
    logic signed [CORDIC_W-1:0] r_ys  [STEPS+1];
    logic signed [ACC_W-1:0]    r_acc [STEPS+1];
    t_flags                     r_flg [STEPS+1];
    logic signed [ANGLE_W-1:0]  r_angle;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xs[0]           <= {{(CORDIC_W-ROOT_W){1'b0}}, i_mag};
            r_ys[0]           <= {{YS_PAD{i_opp[SAMPLE_WIDTH]}}, i_opp, {FRAC_H{1'b0}}};
            r_acc[0]          <= '0;
            r_flg[0].zero_mag <= (i_mag == '0);
            r_flg[0].zero_opp <= (i_opp == '0);
            r_flg[0].neg      <= i_opp[SAMPLE_WIDTH];
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_rot
        logic signed [CORDIC_W-1:0] w_dx;
        logic signed [CORDIC_W-1:0] w_dy;
        logic signed [ACC_W-1:0]    w_ang;

        assign w_dx  = r_ys[i] >>> i;
        assign w_dy  = r_xs[i] >>> i;
        assign w_ang = $signed(atan_entry(i));

        // rotate toward the x axis
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_ys[i][CORDIC_W-1]) begin
                    r_xs[i+1]  <= r_xs[i] + w_dx;
                    r_ys[i+1]  <= r_ys[i] - w_dy;
                    r_acc[i+1] <= r_acc[i] + w_ang;
                end else begin
                    r_xs[i+1]  <= r_xs[i] - w_dx;
                    r_ys[i+1]  <= r_ys[i] + w_dy;
                    r_acc[i+1] <= r_acc[i] - w_ang;
                end
                r_flg[i+1] <= r_flg[i];
            end
        end
    end

    logic [ACC_W-1:0]          w_abs;
    logic [ACC_W-1:0]          w_rnd;
    logic [ACC_W-17:0]         w_q;
    logic [ANGLE_W-1:0]        w_qc;
    logic signed [ANGLE_W-1:0] w_res;
    logic signed [ANGLE_W-1:0] n_angle;

    always_comb begin
        w_abs = r_acc[STEPS][ACC_W-1] ? ACC_W'(-r_acc[STEPS]) : ACC_W'(r_acc[STEPS]);
        w_rnd = w_abs + ACC_W'(32768);
        w_q   = w_rnd[ACC_W-1:16];
        w_qc  = (w_q > (ACC_W-16)'(ANGLE_LIMIT)) ? ANGLE_W'(ANGLE_LIMIT) : w_q[ANGLE_W-1:0];
        w_res = r_acc[STEPS][ACC_W-1] ? -$signed(w_qc) : $signed(w_qc);
        if (r_flg[STEPS].zero_mag) begin
            if (r_flg[STEPS].zero_opp) begin
                n_angle = '0;
            end else if (r_flg[STEPS].neg) begin
                n_angle = -$signed(ANGLE_W'(ANGLE_LIMIT));
            end else begin
                n_angle = $signed(ANGLE_W'(ANGLE_LIMIT));
            end
        end else if (r_flg[STEPS].zero_opp) begin
            n_angle = '0;
        end else begin
            n_angle = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

// ===== src/accel_tilt_angles.sv =====
// Accelerometer tilt angles: pitch/roll via square root and CORDIC pipelines.
// Depends on atl_pkg, atl_isqrt and atl_cordic.
//
// Takes one x/y/z sample per cycle and returns atan2(y, sqrt(x^2+z^2)) and
// atan2(-x, sqrt(y^2+z^2)) in 0.01 degree, rounded, within +/-9000. The stages are
// the squares stage, the sums stage, 31 square-root stages, one CORDIC setup
// stage, one stage per micro-rotation and one rounding stage. Throughput is one
// transaction per cycle; the whole pipeline holds while a result waits on the
// output.
module accel_tilt_angles import atl_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_z,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [ANGLE_W-1:0] o_tilt_about_x,
    output logic signed [ANGLE_W-1:0] o_tilt_about_y
);

    localparam int STEPS  = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int LAT    = 2 + ROOT_W + STEPS + 2;
    localparam int SQ_W   = 2 * SAMPLE_WIDTH;
    localparam int FRAC_H = 31 - SAMPLE_WIDTH;
    localparam int OPP_W  = SAMPLE_WIDTH + 1;

    logic w_en;
    logic [LAT-1:0] r_vld;

    logic [SQ_W-1:0]         r_xx, r_yy, r_zz;
    logic [SQ_W-1:0]         r_sum_a, r_sum_b;
    logic signed [OPP_W-1:0] r_opp_a1, r_opp_b1;
    logic signed [OPP_W-1:0] r_opp_a  [ROOT_W+1];
    logic signed [OPP_W-1:0] r_opp_b  [ROOT_W+1];
    logic [ROOT_W-1:0]       w_mag_a, w_mag_b;

    // advance everything unless a finished result is held
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xx     <= SQ_W'(i_accel_x * i_accel_x);
            r_yy     <= SQ_W'(i_accel_y * i_accel_y);
            r_zz     <= SQ_W'(i_accel_z * i_accel_z);
            r_opp_a1 <= OPP_W'(i_accel_y);
            r_opp_b1 <= -OPP_W'(i_accel_x);
            r_sum_a  <= r_xx + r_zz;
            r_sum_b  <= r_yy + r_zz;
            r_opp_a[0] <= r_opp_a1;
            r_opp_b[0] <= r_opp_b1;
            for (int k = 1; k <= ROOT_W; k++) begin
                r_opp_a[k] <= r_opp_a[k-1];
                r_opp_b[k] <= r_opp_b[k-1];
            end
        end
    end

    atl_isqrt u_sqrt_a (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  ({r_sum_a, {(2*FRAC_H){1'b0}}}),
        .o_root (w_mag_a)
    );

    atl_isqrt u_sqrt_b (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  ({r_sum_b, {(2*FRAC_H){1'b0}}}),
        .o_root (w_mag_b)
    );

    atl_cordic #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STEPS        (STEPS)
    ) u_cordic_a (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_mag   (w_mag_a),
        .i_opp   (r_opp_a[ROOT_W]),
        .o_angle (o_tilt_about_x)
    );

    atl_cordic #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STEPS        (STEPS)
    ) u_cordic_b (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_mag   (w_mag_b),
        .i_opp   (r_opp_b[ROOT_W]),
        .o_angle (o_tilt_about_y)
    );

    assign o_out_valid = r_vld[LAT-1];

endmodule

// ===== src/atl_checker.sv =====
// Port-level checks for the tilt-angle block, bound to its top level.
// Depends on atl_pkg and accel_tilt_angles_macros.svh.
`include "accel_tilt_angles_macros.svh"

module atl_checker import atl_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic signed [ANGLE_W-1:0] o_tilt_about_x,
    input logic signed [ANGLE_W-1:0] o_tilt_about_y
);

    `ATL_ASSERT_NOW(a_range_x, i_clk, i_rst_n, o_out_valid, (o_tilt_about_x >= -ANGLE_LIMIT) && (o_tilt_about_x <= ANGLE_LIMIT), "tilt_about_x out of range")
    `ATL_ASSERT_NOW(a_range_y, i_clk, i_rst_n, o_out_valid, (o_tilt_about_y >= -ANGLE_LIMIT) && (o_tilt_about_y <= ANGLE_LIMIT), "tilt_about_y out of range")
    `ATL_ASSERT_NOW(a_ready_free, i_clk, i_rst_n, !o_out_valid || i_out_ready, o_in_ready, "input stalled without a held result")
    `ATL_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_tilt_about_x) && $stable(o_tilt_about_y), "held result changed")

endmodule

bind accel_tilt_angles atl_checker u_atl_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for accel_tilt_angles: pitch/roll angles checked against a predictor.
// Depends on atl_pkg and the accel_tilt_angles RTL; needs nothing else.
`timescale 1ns / 1ps

module testbench;
    import atl_pkg::*;

    localparam int SW           = SAMPLE_WIDTH_DEF;
    localparam int STEPS        = CORDIC_STEPS_DEF;
    localparam int FRAC_H       = 31 - SW;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 345;

    class tilt_scoreboard;
        logic signed [ANGLE_W-1:0] want_x_q[$];
        logic signed [ANGLE_W-1:0] want_y_q[$];
        int errors;
        int samples;
        int angles_checked;

        function automatic longint unsigned isqrt_floor(longint unsigned n);
            longint unsigned root;
            longint unsigned b;
            root = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= root + b) begin
                    n = n - (root + b);
                    root = (root >> 1) + b;
                end else begin
                    root = root >> 1;
                end
                b = b >> 2;
            end
            return root;
        endfunction

        // atan2(opp, sqrt(a^2 + b^2)) in 0.01 degree
        function automatic logic signed [ANGLE_W-1:0] tilt_angle(longint opp, longint a,
                                                                longint b);
            longint atan_q16[24] = '{
                294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
                5866610, 2933484, 1466765, 733385, 366693, 183346,
                91673, 45837, 22918, 11459, 5730, 2865,
                1432, 716, 358, 179, 90, 45};
            longint unsigned sum;
            longint xs, ys, acc, dx, dy, mag, q;
            sum = longint'(a * a) + longint'(b * b);
            xs = longint'(isqrt_floor(sum << (2 * FRAC_H)));
            if (xs == 0) begin
                q = (opp > 0) ? ANGLE_LIMIT : ((opp < 0) ? -ANGLE_LIMIT : 0);
                return q[ANGLE_W-1:0];
            end
            if (opp == 0) return '0;
            ys = opp * (64'sd1 <<< FRAC_H);
            acc = 0;
            for (int i = 0; i < STEPS && i < 24; i++) begin
                dx = ys >>> i;
                dy = xs >>> i;
                if (ys >= 0) begin
                    xs = xs + dx;
                    ys = ys - dy;
                    acc = acc + atan_q16[i];
                end else begin
                    xs = xs - dx;
                    ys = ys + dy;
                    acc = acc - atan_q16[i];
                end
            end
            mag = (acc < 0) ? -acc : acc;
            q = (mag + 32768) >>> 16;
            if (q > ANGLE_LIMIT) q = ANGLE_LIMIT;
            if (acc < 0) q = -q;
            return q[ANGLE_W-1:0];
        endfunction

        function void note_sample(logic signed [SW-1:0] x, logic signed [SW-1:0] y,
                                  logic signed [SW-1:0] z);
            longint lx, ly, lz;
            lx = x;
            ly = y;
            lz = z;
            want_x_q.push_back(tilt_angle(ly, lx, lz));
            want_y_q.push_back(tilt_angle(-lx, ly, lz));
            samples++;
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_angles(logic signed [ANGLE_W-1:0] got_x, logic signed [ANGLE_W-1:0] got_y);
            logic signed [ANGLE_W-1:0] wx, wy;
            if (want_x_q.size() == 0) begin
                report($sformatf("unexpected transaction x=%0d y=%0d", got_x, got_y));
            end else begin
                wx = want_x_q.pop_front();
                wy = want_y_q.pop_front();
                angles_checked++;
                if (got_x !== wx)
                    report($sformatf("tilt_about_x got %0d want %0d", got_x, wx));
                if (got_y !== wy)
                    report($sformatf("tilt_about_y got %0d want %0d", got_y, wy));
            end
        endtask

        function int pending();
            return want_x_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic signed [SW-1:0] i_accel_x, i_accel_y, i_accel_z;
    logic o_out_valid;
    logic i_out_ready;
    logic signed [ANGLE_W-1:0] o_tilt_about_x, o_tilt_about_y;

    accel_tilt_angles u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_tilt_about_x (o_tilt_about_x),
        .o_tilt_about_y (o_tilt_about_y)
    );

    tilt_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    bit in_fire, out_fire;
    logic signed [ANGLE_W-1:0] seen_x, seen_y;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Sample handshakes mid-cycle, where everything has settled.
    always @(negedge i_clk) begin
        in_fire  = i_rst_n && i_in_valid && o_in_ready;
        out_fire = i_rst_n && o_out_valid && i_out_ready;
        seen_x   = o_tilt_about_x;
        seen_y   = o_tilt_about_y;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_request > 0 || hold_left > 0) begin
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (out_fire) sb.check_angles(seen_x, seen_y);
        if (in_fire || out_fire || !i_rst_n) begin
            quiet_cycles = 0;
        end else if (++quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_sample(logic signed [SW-1:0] x, logic signed [SW-1:0] y,
                               logic signed [SW-1:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_accel_x  <= x;
        i_accel_y  <= y;
        i_accel_z  <= z;
        do begin
            @(negedge i_clk);
            @(posedge i_clk);
        end while (!in_fire);
        sb.note_sample(x, y, z);
    endtask

    function automatic logic signed [SW-1:0] pick_axis(int mode);
        logic signed [SW-1:0] corners[6] = '{16'sh8000, 16'sh7fff, 16'sh0001,
                                            16'shffff, 16'sh0000, 16'sh4000};
        case (mode)
            0: return SW'($urandom());
            1: return SW'($urandom_range(16) - 8);
            2: return corners[$urandom_range(5)];
            default: return ($urandom_range(3) == 0) ? 16'sh0
                                                     : SW'($urandom_range(2000) - 1000);
        endcase
    endfunction

    task automatic random_phase(int count);
        int mode;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(99);
            mode = (mode < 50) ? 0 : (mode < 70) ? 1 : (mode < 85) ? 2 : 3;
            send_sample(pick_axis(mode), pick_axis(mode), pick_axis(mode));
        end
    endtask

    task automatic drain_all();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_accel_x  <= '0;
        i_accel_y  <= '0;
        i_accel_z  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero sample, zero magnitude with a signed opposite side, single axes
        send_sample(16'sh0000, 16'sh0000, 16'sh0000);
        send_sample(16'sh0000, 16'sh7fff, 16'sh0000);
        send_sample(16'sh0000, 16'sh8000, 16'sh0000);
        send_sample(16'sh7fff, 16'sh0000, 16'sh0000);
        send_sample(16'sh8000, 16'sh0000, 16'sh0000);
        send_sample(16'sh0000, 16'sh0000, 16'sh7fff);
        send_sample(16'sh0000, 16'sh0000, 16'sh8000);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
        send_sample(16'sh7fff, 16'sh8000, 16'sh0001);
        send_sample(16'sh0001, 16'sh0001, 16'sh0001);
        send_sample(16'shffff, 16'shffff, 16'shffff);
        send_sample(16'sh0001, 16'sh0000, 16'sh0000);
        send_sample(16'sh0000, 16'shffff, 16'sh0000);
        send_sample(16'sh0001, 16'sh7fff, 16'sh0000);
        send_sample(16'sh7fff, 16'sh0001, 16'sh0000);
        send_sample(16'sh0000, 16'sh0000, 16'sh0001);
        send_sample(16'sh5555, 16'shaaaa, 16'sh5555);
        send_sample(16'shaaaa, 16'sh5555, 16'shaaaa);

        send_idle_pct = 15;
        recv_idle_pct = 69;
        random_phase(PHASE_ITEMS);

        // pause the sender until the pipeline is empty
        drain_all();
        send_idle_pct = 69;
        recv_idle_pct = 15;
        random_phase(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 300;
        random_phase(PHASE_ITEMS);

        drain_all();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d samples (axis extremes, zero cases, small and random values)",
                 sb.samples);
        $display("checked %0d angle pairs under idle, stall and back-pressure mixes",
                 sb.angles_checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/atl_pkg.sv
src/atl_isqrt.sv
src/atl_cordic.sv
src/accel_tilt_angles.sv
src/atl_checker.sv
bench/testbench.sv
